@@ hw/rtl/clipped_box_blur_3x3_core_defines.svh @@
// Assertion macros for the checker file of the box blur core.
`ifndef CLIPPED_BOX_BLUR_3X3_CORE_DEFINES_SVH
`define CLIPPED_BOX_BLUR_3X3_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CBB_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box blur check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CBB_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("box blur check failed");

`endif

@@ hw/rtl/cbb_pkg.sv @@
// Types, constants and helper functions of the 3x3 clipped box blur core.
package cbb_pkg;

   localparam int MAX_SIDE  = 64;
   localparam int MIN_SIDE  = 3;
   localparam int CH_W      = 16;
   localparam int PIX_W     = 3 * CH_W;
   localparam int POS_W     = $clog2(MAX_SIDE);
   localparam int SIDE_W    = POS_W + 1;
   localparam int SUM_W     = 20;
   localparam int CNT_W     = 4;
   localparam int DIV_SHIFT = 24;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam int WIN_N     = 9;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [POS_W-1:0] pos_type;

   // One window snapshot together with the block of outputs it completes.
   typedef struct packed {
      logic [WIN_N-1:0][PIX_W-1:0] win;
      pos_type                     r_in;
      pos_type                     c_in;
      pos_type                     r_lo;
      pos_type                     r_hi;
      pos_type                     c_lo;
      pos_type                     c_hi;
   } job_type;

   // Scaled reciprocal of a window count: q = (sum * recip) >> DIV_SHIFT is
   // exact for every sum below 2**SUM_W.
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] m;
      case (cnt)
         CNT_W'(1): m = RECIP_W'(1) << DIV_SHIFT;
         CNT_W'(2): m = RECIP_W'(1) << (DIV_SHIFT - 1);
         CNT_W'(3): m = RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);
         CNT_W'(4): m = RECIP_W'(1) << (DIV_SHIFT - 2);
         CNT_W'(6): m = RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd5) / 64'd6);
         CNT_W'(9): m = RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);
         default:   m = '0;
      endcase
      return m;
   endfunction

endpackage

@@ hw/rtl/clipped_box_blur_3x3_core.sv @@
// Top level of the streaming 3x3 clipped box blur core.
// Takes one raster-order RGB pixel per cycle and returns, per output pixel,
// the truncated mean over its 3x3 window with out-of-frame neighbors dropped.
// Most pixels cause no result or one; a row end or a pixel of the last row
// causes up to three results and the last pixel of a frame up to nine. The
// output sequencer produces one result per cycle while the output is ready.
// With the output side ready, input stalls only while the sequencer is busy
// with a run of more than one; a stalled output stalls the input as soon as
// the pipeline behind it fills. After its transfer a pixel passes the intake
// stage, the job register and the sum register before its first result is in
// the output register. The line stores need no clearing pass after reset.
// Writing the frame size restarts the frame at row 0, column 0.
module clipped_box_blur_3x3_core import cbb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIDE_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CH_W-1:0]   req_in_red,
   input  logic [CH_W-1:0]   req_in_green,
   input  logic [CH_W-1:0]   req_in_blue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [POS_W-1:0]  rsp_out_row,
   output logic [POS_W-1:0]  rsp_out_col,
   output logic [CH_W-1:0]   rsp_out_red,
   output logic [CH_W-1:0]   rsp_out_green,
   output logic [CH_W-1:0]   rsp_out_blue,
   output logic              rsp_run_last
);

   logic    job_ready, job_load;
   job_type job;

   cbb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .job_ready    (job_ready),
      .job_load     (job_load),
      .job          (job)
   );

   cbb_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .job_load      (job_load),
      .job           (job),
      .job_ready     (job_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

@@ hw/rtl/cbb_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module cbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cbb_front.sv @@
// Pixel intake: position counters, the two line stores and the column window.
module cbb_front import cbb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [SIDE_W-1:0]   csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CH_W-1:0]     req_in_red,
   input  logic [CH_W-1:0]     req_in_green,
   input  logic [CH_W-1:0]     req_in_blue,
   input  logic                job_ready,
   output logic                job_load,
   output job_type             job
);

   logic [SIDE_W-1:0] frame_size_ff;
   pos_type           row_ff, row_in, col_ff, col_in;
   logic              s1_valid_ff, s1_valid_in;
   pixel_type         s1_px_ff;
   pos_type           s1_r_ff, s1_c_ff;
   pixel_type         cw_ff [6];

   logic [SIDE_W-1:0] side, c_next, r_next;
   pos_type           smax, r_cur, c_cur;
   logic              wrap, req_xfer, s1_adv, r_ok, c_ok, has_out;
   pixel_type         older_rd, newer_rd;

   always_comb begin
      if (frame_size_ff < SIDE_W'(MIN_SIDE)) begin
         side = SIDE_W'(MIN_SIDE);
      end else if (frame_size_ff > SIDE_W'(MAX_SIDE)) begin
         side = SIDE_W'(MAX_SIDE);
      end else begin
         side = frame_size_ff;
      end
   end

   assign smax  = POS_W'(side - SIDE_W'(1));
   assign wrap  = ({1'b0, row_ff} >= side) || ({1'b0, col_ff} >= side);
   assign r_cur = wrap ? '0 : row_ff;
   assign c_cur = wrap ? '0 : col_ff;

   assign req_xfer  = req_valid && req_ready;
   assign req_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      c_next = {1'b0, c_cur} + SIDE_W'(1);
      r_next = {1'b0, r_cur} + SIDE_W'(1);
      row_in = row_ff;
      col_in = col_ff;
      if (csr_wr_en) begin
         row_in = '0;
         col_in = '0;
      end else if (req_xfer) begin
         row_in = r_cur;
         col_in = c_next[POS_W-1:0];
         if (c_next >= side) begin
            col_in = '0;
            row_in = (r_next >= side) ? '0 : r_next[POS_W-1:0];
         end
      end
   end

   // Output range along each axis completed by the intake-stage pixel, and its window.
   always_comb begin
      job.r_in = s1_r_ff;
      job.c_in = s1_c_ff;
      job.r_lo = '0;
      job.r_hi = '0;
      job.c_lo = '0;
      job.c_hi = '0;
      r_ok     = 1'b1;
      c_ok     = 1'b1;
      if (s1_r_ff == smax) begin
         job.r_lo = s1_r_ff - POS_W'(2);
         job.r_hi = s1_r_ff;
      end else if (s1_r_ff >= POS_W'(2)) begin
         job.r_lo = s1_r_ff - POS_W'(2);
         job.r_hi = s1_r_ff - POS_W'(2);
      end else begin
         r_ok = 1'b0;
      end
      if (s1_c_ff == smax) begin
         job.c_lo = s1_c_ff - POS_W'(2);
         job.c_hi = s1_c_ff;
      end else if (s1_c_ff >= POS_W'(2)) begin
         job.c_lo = s1_c_ff - POS_W'(2);
         job.c_hi = s1_c_ff - POS_W'(2);
      end else begin
         c_ok = 1'b0;
      end
      job.win[0] = cw_ff[3];
      job.win[1] = cw_ff[0];
      job.win[2] = older_rd;
      job.win[3] = cw_ff[4];
      job.win[4] = cw_ff[1];
      job.win[5] = newer_rd;
      job.win[6] = cw_ff[5];
      job.win[7] = cw_ff[2];
      job.win[8] = s1_px_ff;
   end

   assign has_out  = r_ok && c_ok;
   assign s1_adv   = s1_valid_ff && (job_ready || !has_out);
   assign job_load = s1_adv && has_out;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= SIDE_W'(MAX_SIDE);
         row_ff        <= '0;
         col_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            cw_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            frame_size_ff <= csr_wr_data;
         end
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            cw_ff[3] <= cw_ff[0];
            cw_ff[4] <= cw_ff[1];
            cw_ff[5] <= cw_ff[2];
            cw_ff[0] <= older_rd;
            cw_ff[1] <= newer_rd;
            cw_ff[2] <= s1_px_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_px_ff <= {req_in_blue, req_in_green, req_in_red};
         s1_r_ff  <= r_cur;
         s1_c_ff  <= c_cur;
      end
   end

   // Within a row the write lands one column behind the read of the next pixel, so
   // the two ports touch the same entry in one cycle only after a frame size write.
   cbb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_older_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_c_ff),
      .wr_data (newer_rd),
      .rd_en   (req_xfer),
      .rd_addr (c_cur),
      .rd_data (older_rd)
   );

   cbb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_newer_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_c_ff),
      .wr_data (s1_px_ff),
      .rd_en   (req_xfer),
      .rd_addr (c_cur),
      .rd_data (newer_rd)
   );

endmodule

@@ hw/rtl/cbb_emit.sv @@
// Output sequencer: walks a window's outputs, sums the clipped window, divides.
module cbb_emit import cbb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_load,
   input  job_type         job,
   output logic            job_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output pos_type         rsp_out_row,
   output pos_type         rsp_out_col,
   output logic [CH_W-1:0] rsp_out_red,
   output logic [CH_W-1:0] rsp_out_green,
   output logic [CH_W-1:0] rsp_out_blue,
   output logic            rsp_run_last
);

   logic              job_valid_ff;
   job_type           job_ff;
   pos_type           cur_r_ff, cur_c_ff;

   logic              sum_valid_ff;
   logic [SUM_W-1:0]  sum_ff [3];
   logic [CNT_W-1:0]  cnt_ff;
   pos_type           sr_ff, sc_ff;
   logic              slast_ff;

   logic              out_valid_ff;
   pos_type           or_ff, oc_ff;
   logic [CH_W-1:0]   oq_ff [3];
   logic              olast_ff;

   logic              out_free, sum_adv, sum_free, emit, last;
   logic [1:0]        d_r, d_c;
   logic [SUM_W-1:0]  acc [3];
   logic [CNT_W-1:0]  cnt;
   logic [RECIP_W-1:0] m;
   logic [PROD_W-1:0] prod [3];

   assign out_free  = !out_valid_ff || rsp_ready;
   assign sum_adv   = sum_valid_ff && out_free;
   assign sum_free  = !sum_valid_ff || sum_adv;
   assign emit      = job_valid_ff && sum_free;
   assign last      = (cur_r_ff == job_ff.r_hi) && (cur_c_ff == job_ff.c_hi);
   assign job_ready = !job_valid_ff || (emit && last);

   // Window rows and columns that lie inside the frame for this output.
   assign d_r = 2'(job_ff.r_in - cur_r_ff);
   assign d_c = 2'(job_ff.c_in - cur_c_ff);
   assign cnt = CNT_W'(({2'b0, d_r} + CNT_W'(1)) * ({2'b0, d_c} + CNT_W'(1)));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc[k] = '0;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if ((3'(i) + {1'b0, d_r} >= 3'd2) && (3'(j) + {1'b0, d_c} >= 3'd2)) begin
               for (int k = 0; k < 3; k++) begin
                  acc[k] = acc[k] + SUM_W'(job_ff.win[i*3+j][k*CH_W +: CH_W]);
               end
            end
         end
      end
   end

   assign m = recip(cnt_ff);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k] = PROD_W'(sum_ff[k]) * PROD_W'(m);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_load) begin
            job_valid_ff <= 1'b1;
         end else if (emit && last) begin
            job_valid_ff <= 1'b0;
         end
         if (emit) begin
            sum_valid_ff <= 1'b1;
         end else if (sum_adv) begin
            sum_valid_ff <= 1'b0;
         end
         if (sum_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff   <= job;
         cur_r_ff <= job.r_lo;
         cur_c_ff <= job.c_lo;
      end else if (emit && !last) begin
         if (cur_c_ff == job_ff.c_hi) begin
            cur_c_ff <= job_ff.c_lo;
            cur_r_ff <= cur_r_ff + POS_W'(1);
         end else begin
            cur_c_ff <= cur_c_ff + POS_W'(1);
         end
      end
      if (emit) begin
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= acc[k];
         end
         cnt_ff   <= cnt;
         sr_ff    <= cur_r_ff;
         sc_ff    <= cur_c_ff;
         slast_ff <= last;
      end
      if (sum_adv) begin
         for (int k = 0; k < 3; k++) begin
            oq_ff[k] <= prod[k][DIV_SHIFT +: CH_W];
         end
         or_ff    <= sr_ff;
         oc_ff    <= sc_ff;
         olast_ff <= slast_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_row   = or_ff;
   assign rsp_out_col   = oc_ff;
   assign rsp_out_red   = oq_ff[0];
   assign rsp_out_green = oq_ff[1];
   assign rsp_out_blue  = oq_ff[2];
   assign rsp_run_last  = olast_ff;

endmodule

@@ hw/rtl/cbb_checker.sv @@
// Port-level checks on the box blur core, bound to its top level.
`include "clipped_box_blur_3x3_core_defines.svh"

module cbb_checker import cbb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              csr_wr_en,
   input logic [SIDE_W-1:0] csr_wr_data,
   input logic              req_valid,
   input logic              req_ready,
   input logic [CH_W-1:0]   req_in_red,
   input logic [CH_W-1:0]   req_in_green,
   input logic [CH_W-1:0]   req_in_blue,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [POS_W-1:0]  rsp_out_row,
   input logic [POS_W-1:0]  rsp_out_col,
   input logic [CH_W-1:0]   rsp_out_red,
   input logic [CH_W-1:0]   rsp_out_green,
   input logic [CH_W-1:0]   rsp_out_blue,
   input logic              rsp_run_last
);

   logic                           rsp_at_corner;
   logic [2*POS_W+3*CH_W:0]        rsp_payload;

   assign rsp_at_corner = (rsp_out_row == POS_W'(MAX_SIDE - 1)) &&
                          (rsp_out_col == POS_W'(MAX_SIDE - 1));
   assign rsp_payload   = {rsp_out_row, rsp_out_col, rsp_out_red, rsp_out_green,
                           rsp_out_blue, rsp_run_last};

   // Reset empties every stage, so nothing is offered right after it.
   `CBB_ASSERT_IMP(a_reset_empties, $past(reset), !rsp_valid)

   // The bottom-right pixel of the largest frame always closes its run.
   `CBB_ASSERT_IMP(a_corner_closes_run, rsp_valid && !rsp_run_last, !rsp_at_corner)

   `CBB_ASSERT_NXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid)

   `CBB_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_payload))

endmodule

bind clipped_box_blur_3x3_core cbb_checker u_cbb_checker (.*);
